FILE: src/assert_macros.svh
// assertion macros shared by the voice allocator rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: src/svalloc_pkg.sv
// types, codes and helpers for the voice allocator
// no dependencies
`timescale 1ns / 1ps

package svalloc_pkg;

    localparam int NUM_VOICES = 16;
    localparam int VOICE_W    = $clog2(NUM_VOICES);
    localparam int AGE_W      = 32;
    localparam int LEVEL_W    = 17;
    localparam int SCORE_W    = AGE_W + 1;

    typedef enum logic [2:0] {
        OP_NOTE_ON        = 3'd0,
        OP_NOTE_OFF       = 3'd1,
        OP_PEDAL          = 3'd2,
        OP_ALL_NOTES_OFF  = 3'd3,
        OP_LEVEL_REPORT   = 3'd4,
        OP_VOICE_FINISHED = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_START       = 2'd0,
        KIND_RELEASE     = 2'd1,
        KIND_ENV_RELEASE = 2'd2,
        KIND_RESET_ALL   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCORE,
        ST_START,
        ST_LIST,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [2:0]          op;
        logic [6:0]          note;
        logic [3:0]          chan;
        logic [6:0]          velocity;
        logic signed [15:0]  bend;
        logic [15:0]         pressure;
        logic [15:0]         timbre;
        logic                pedal_down;
        logic [3:0]          voice_sel;
        logic [LEVEL_W-1:0]  env_level;
    } t_in_word;

    typedef struct packed {
        t_kind               kind;
        logic [3:0]          voice;
        logic [6:0]          out_note;
        logic [3:0]          out_chan;
        logic [6:0]          out_velocity;
        logic signed [15:0]  out_bend;
        logic [15:0]         out_pressure;
        logic [15:0]         out_timbre;
        logic                stolen;
        logic                last;
    } t_out_word;

    // one scoring step of the shared compare unit
    typedef struct packed {
        logic               step;
        logic               first;
        logic [VOICE_W-1:0] idx;
    } t_score_ctl;

    // index of the lowest set bit, zero for an empty vector
    function automatic logic [VOICE_W-1:0] lowest_set(input logic [NUM_VOICES-1:0] vec);
        logic [VOICE_W-1:0] res;
        res = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--) begin
            if (vec[i]) begin
                res = VOICE_W'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: src/svalloc_score_unit.sv
// shared score unit: adds level and age distance, keeps the running minimum
// depends on svalloc_pkg
`timescale 1ns / 1ps

module svalloc_score_unit (
    input  logic                                i_clk,
    input  svalloc_pkg::t_score_ctl             i_ctl,
    input  logic [svalloc_pkg::LEVEL_W-1:0]     i_level,
    input  logic [svalloc_pkg::AGE_W-1:0]       i_age_diff,
    output logic [svalloc_pkg::VOICE_W-1:0]     o_best_idx
);
    import svalloc_pkg::*;

    logic [SCORE_W-1:0] w_score;
    logic [SCORE_W-1:0] r_best_score;
    logic [VOICE_W-1:0] r_best_idx;

    assign w_score = SCORE_W'(i_level) + SCORE_W'(i_age_diff);

    // strict less-than keeps the lower index on a tie
    always_ff @(posedge i_clk) begin
        if (i_ctl.step && (i_ctl.first || (w_score < r_best_score))) begin
            r_best_score <= w_score;
            r_best_idx   <= i_ctl.idx;
        end
    end

    assign o_best_idx = r_best_idx;

endmodule

FILE: src/svalloc_out_reg.sv
// output register holding one result word until it is taken
// depends on svalloc_pkg
`timescale 1ns / 1ps

module svalloc_out_reg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  svalloc_pkg::t_out_word  i_word,
    input  logic                    i_ready,
    output logic                    o_valid,
    output svalloc_pkg::t_out_word  o_word,
    output logic                    o_free
);
    import svalloc_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: src/synth_voice_allocator_top.sv
// note_on: a free voice goes straight to issue; when a voice is stolen
// each voice is scored in turn through the shared score unit before the word is issued
// note_off (pedal up), pedal release: a word per cycle per affected voice unless stalled
// all_notes_off: one word; other ops finish in the accept cycle
// a waiting output word stalls issue; the input is taken again once the sequencer is idle
// synchronous reset clears all voice state, the pedal and the age counter
`timescale 1ns / 1ps
`include "assert_macros.svh"

module synth_voice_allocator_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  svalloc_pkg::t_in_word   i_in_word,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output svalloc_pkg::t_out_word  o_out_word
);
    import svalloc_pkg::*;

    // voice table
    logic [NUM_VOICES-1:0] r_active;
    logic [NUM_VOICES-1:0] r_held;
    logic [6:0]            r_note  [NUM_VOICES];
    logic [3:0]            r_chan  [NUM_VOICES];
    logic [AGE_W-1:0]      r_age   [NUM_VOICES];
    logic [LEVEL_W-1:0]    r_level [NUM_VOICES];
    logic [AGE_W-1:0]      r_age_count;
    logic                  r_pedal;

    // sequencer
    t_state                r_state;
    t_state                n_state;
    logic [VOICE_W-1:0]    r_idx;
    logic [NUM_VOICES-1:0] r_hits;
    logic                  r_stolen;
    t_in_word              r_in;
    logic [VOICE_W-1:0]    r_free_voice;
    t_kind                 r_list_kind;

    logic                  w_accept;
    logic [NUM_VOICES-1:0] w_match;
    logic [VOICE_W-1:0]    w_sel;
    logic                  w_sel_ok;
    logic [VOICE_W-1:0]    w_pick;
    logic [NUM_VOICES-1:0] w_hits_rest;
    logic [VOICE_W-1:0]    w_best_idx;
    logic [VOICE_W-1:0]    w_start_voice;
    logic [AGE_W-1:0]      w_age_next;
    t_score_ctl            w_score_ctl;
    logic                  w_out_free;
    logic                  w_load;
    t_out_word             w_word;
    logic                  w_scan_last;
    logic                  w_start_out;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        for (int i = 0; i < NUM_VOICES; i++) begin
            w_match[i] = r_active[i] && (r_note[i] == i_in_word.note)
                         && (r_chan[i] == i_in_word.chan);
        end
    end

    assign w_sel       = VOICE_W'(i_in_word.voice_sel);
    assign w_sel_ok    = int'(i_in_word.voice_sel) < NUM_VOICES;
    assign w_pick      = lowest_set(r_hits);
    assign w_hits_rest = r_hits & ~(NUM_VOICES'(1) << w_pick);
    assign w_start_voice = r_stolen ? w_best_idx : r_free_voice;
    assign w_age_next  = r_age_count + AGE_W'(1);
    assign w_scan_last = (r_state == ST_SCORE) && (r_idx == VOICE_W'(NUM_VOICES - 1));
    assign w_start_out = o_out_valid && (o_out_word.kind == KIND_START);

    assign w_score_ctl.step  = (r_state == ST_SCORE);
    assign w_score_ctl.first = (r_idx == '0);
    assign w_score_ctl.idx   = r_idx;

    svalloc_score_unit u_score (
        .i_clk      (i_clk),
        .i_ctl      (w_score_ctl),
        .i_level    (r_level[r_idx]),
        .i_age_diff (r_age_count - r_age[r_idx]),
        .o_best_idx (w_best_idx)
    );

    svalloc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_word  (w_word),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .o_free  (w_out_free)
    );

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        w_word  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (t_op'(i_in_word.op))
                        OP_NOTE_ON: begin
                            n_state = (&r_active) ? ST_SCORE : ST_START;
                        end
                        OP_NOTE_OFF: begin
                            if (!r_pedal && (|w_match)) begin
                                n_state = ST_LIST;
                            end
                        end
                        OP_PEDAL: begin
                            if (!i_in_word.pedal_down && (|r_held)) begin
                                n_state = ST_LIST;
                            end
                        end
                        OP_ALL_NOTES_OFF: begin
                            n_state = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCORE: begin
                if (w_scan_last) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (w_out_free) begin
                    w_load              = 1'b1;
                    w_word.kind         = KIND_START;
                    w_word.voice        = 4'(w_start_voice);
                    w_word.out_note     = r_in.note;
                    w_word.out_chan     = r_in.chan;
                    w_word.out_velocity = r_in.velocity;
                    w_word.out_bend     = r_in.bend;
                    w_word.out_pressure = r_in.pressure;
                    w_word.out_timbre   = r_in.timbre;
                    w_word.stolen       = r_stolen;
                    w_word.last         = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (w_out_free) begin
                    w_load          = 1'b1;
                    w_word.kind     = r_list_kind;
                    w_word.voice    = 4'(w_pick);
                    w_word.out_note = r_note[w_pick];
                    w_word.out_chan = r_chan[w_pick];
                    w_word.last     = (w_hits_rest == '0);
                    if (w_hits_rest == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_word.kind = KIND_RESET_ALL;
                    w_word.last = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_held      <= '0;
            r_age_count <= '0;
            r_pedal     <= 1'b0;
            r_idx       <= '0;
            r_hits      <= '0;
            r_stolen    <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_note[i]  <= '0;
                r_chan[i]  <= '0;
                r_age[i]   <= '0;
                r_level[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                case (t_op'(i_in_word.op))
                    OP_NOTE_ON: begin
                        r_stolen <= &r_active;
                        r_idx    <= '0;
                    end
                    OP_NOTE_OFF: begin
                        // with the pedal down matching voices only become held
                        if (r_pedal) begin
                            r_held <= r_held | w_match;
                        end else begin
                            r_hits <= w_match;
                        end
                    end
                    OP_PEDAL: begin
                        r_pedal <= i_in_word.pedal_down;
                        if (!i_in_word.pedal_down) begin
                            r_hits <= r_held;
                            r_held <= '0;
                        end
                    end
                    OP_ALL_NOTES_OFF: begin
                        r_active <= '0;
                        r_held   <= '0;
                        for (int i = 0; i < NUM_VOICES; i++) begin
                            r_level[i] <= '0;
                        end
                    end
                    OP_LEVEL_REPORT: begin
                        if (w_sel_ok) begin
                            r_level[w_sel] <= i_in_word.env_level;
                        end
                    end
                    OP_VOICE_FINISHED: begin
                        if (w_sel_ok) begin
                            r_active[w_sel] <= 1'b0;
                        end
                    end
                    default: begin
                        r_pedal <= r_pedal;
                    end
                endcase
            end
            if (r_state == ST_SCORE) begin
                r_idx <= r_idx + VOICE_W'(1);
            end
            if (w_load && (r_state == ST_START)) begin
                r_active[w_start_voice] <= 1'b1;
                r_held[w_start_voice]   <= 1'b0;
                r_note[w_start_voice]   <= r_in.note;
                r_chan[w_start_voice]   <= r_in.chan;
                r_age[w_start_voice]    <= w_age_next;
                r_age_count             <= w_age_next;
            end
            if (w_load && (r_state == ST_LIST)) begin
                r_hits <= w_hits_rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in         <= i_in_word;
            r_free_voice <= lowest_set(~r_active);
            r_list_kind  <= (t_op'(i_in_word.op) == OP_PEDAL) ? KIND_ENV_RELEASE : KIND_RELEASE;
        end
    end

    `ASSERT_IMPL(a_list_has_hits, i_clk, i_rst_n, r_state == ST_LIST, r_hits != '0)
    `ASSERT_NEXT(a_scan_ends_in_start, i_clk, i_rst_n, w_scan_last, r_state == ST_START)
    `ASSERT_IMPL(a_start_is_last, i_clk, i_rst_n, w_start_out, o_out_word.last)

endmodule
